>>> rtl/core/bif_pkg.sv
// ----------------------------------------------------------------------------
// bif_pkg
// Shared types and constants for the isolated background fill filter.
// ----------------------------------------------------------------------------
package bif_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned FW_W      = 11;
  localparam int unsigned FH_W      = 13;
  localparam int unsigned ROW_W     = FH_W + 1;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LINE_W    = PIX_W + 1;

  localparam logic [PIX_W-1:0] PIX_BG   = '0;
  localparam logic [PIX_W-1:0] PIX_FILL = '1;

  localparam logic [FW_W-1:0] MAX_WIDTH_FW = FW_W'(MAX_WIDTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             padding;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_of_frame;
  } pix_out_t;

  // one accepted slot as it enters the window stage
  typedef struct packed {
    logic [PIX_W-1:0] val;
    logic [COL_W-1:0] addr;
    logic             emit;
    logic             last;
    logic             has_left;
    logic             has_right;
    logic             has_up;
    logic             has_down;
  } bif_slot_t;

endpackage

>>> rtl/core/bif_ram.sv
// ----------------------------------------------------------------------------
// bif_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bif_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bif_ctrl.sv
// ----------------------------------------------------------------------------
// bif_ctrl
// Frame registers, raster position counters and per-word slot decode.
// ----------------------------------------------------------------------------
module bif_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bif_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bif_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         accept_i,
  input  bif_pkg::pix_in_t             in_data_i,
  output bif_pkg::bif_slot_t           slot_o,
  output logic                         take_o
);
  import bif_pkg::*;

  logic [FW_W-1:0]  width_q, width_d;
  logic [FH_W-1:0]  height_q, height_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             cfg_hit;

  logic [FW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [COL_W-1:0] c;
  logic [FW_W-1:0]  c_ext, c_inc;
  logic             flush;
  logic             c_zero;

  always_comb begin
    w_eff = width_q;
    if (width_q == '0) begin
      w_eff = FW_W'(1);
    end else if (width_q > MAX_WIDTH_FW) begin
      w_eff = MAX_WIDTH_FW;
    end
    h_eff = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);
  end

  always_comb begin
    c      = (FW_W'(col_q) >= w_eff) ? '0 : col_q;
    c_ext  = FW_W'(c);
    c_inc  = c_ext + FW_W'(1);
    c_zero = (c == '0);
    flush  = (row_q >= h_eff);
    take_o = !in_data_i.padding || flush;

    slot_o.val  = flush ? PIX_FILL : in_data_i.pixel_in;
    slot_o.addr = c;
    slot_o.emit = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && !c_zero);
    slot_o.last = (row_q == h_eff + ROW_W'(1)) && c_zero;
    if (c_zero) begin
      slot_o.has_left  = (w_eff > FW_W'(1));
      slot_o.has_right = 1'b0;
      slot_o.has_up    = (row_q > ROW_W'(2));
      slot_o.has_down  = (row_q - ROW_W'(1) < h_eff);
    end else begin
      slot_o.has_left  = (c_ext >= FW_W'(2));
      slot_o.has_right = (c_ext < w_eff);
      slot_o.has_up    = (row_q > ROW_W'(1));
      slot_o.has_down  = (row_q < h_eff);
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          width_d = cfg_data_i[FW_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          height_d = cfg_data_i[FH_W-1:0];
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i && take_o) begin
      if (slot_o.last) begin
        col_d = '0;
        row_d = '0;
      end else if (c_inc >= w_eff) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = c_inc[COL_W-1:0];
      end
    end else begin
      col_d = col_q;
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FW_W'(640);
      height_q <= FH_W'(480);
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

>>> rtl/core/bif_window.sv
// ----------------------------------------------------------------------------
// bif_window
// Line buffer, 3x3 neighborhood window, fill decision and output register.
// ----------------------------------------------------------------------------
module bif_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  bif_pkg::bif_slot_t slot_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bif_pkg::pix_out_t  out_data_o
);
  import bif_pkg::*;

  bif_slot_t        s1_q;
  logic             s1_valid_q;
  logic             s1_adv;

  logic             byp_q;
  logic [LINE_W-1:0] byp_data_q;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line_rd;
  logic [LINE_W-1:0] line_wr;

  logic [PIX_W-1:0] above_q [2];
  logic             upbit_q [2];
  logic [PIX_W-1:0] prev_q;

  logic [PIX_W-1:0] above;
  logic             upbit;
  logic             nb_bg;
  logic [PIX_W-1:0] result;

  logic             out_valid_q;
  pix_out_t         out_q;

  assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign busy_o = s1_valid_q && !s1_adv;

  bif_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_q.addr),
    .wdata_i(line_wr),
    .re_i   (load_i),
    .raddr_i(slot_i.addr),
    .rdata_o(ram_rdata)
  );

  // same-column write and read in one cycle happens for one-pixel rows and across a frame restart
  assign line_rd = byp_q ? byp_data_q : ram_rdata;
  assign above   = line_rd[PIX_W-1:0];
  assign upbit   = line_rd[LINE_W-1];
  assign line_wr = {(above == PIX_BG), s1_q.val};

  always_comb begin
    nb_bg = (s1_q.has_left  && (above_q[0] == PIX_BG)) ||
            (s1_q.has_right && (above == PIX_BG)) ||
            (s1_q.has_up    && upbit_q[1]) ||
            (s1_q.has_up    && s1_q.has_left && upbit_q[0]) ||
            (s1_q.has_down  && (prev_q == PIX_BG)) ||
            (s1_q.has_down  && s1_q.has_right && (s1_q.val == PIX_BG));
    result = above_q[1];
    if ((above_q[1] == PIX_BG) && !nb_bg) begin
      result = PIX_FILL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
      above_q[0]  <= '0;
      above_q[1]  <= '0;
      upbit_q[0]  <= 1'b0;
      upbit_q[1]  <= 1'b0;
      prev_q      <= '0;
    end else begin
      if (load_i) begin
        s1_valid_q <= 1'b1;
        byp_q      <= s1_adv && (s1_q.addr == slot_i.addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        above_q[0]  <= above_q[1];
        above_q[1]  <= above;
        upbit_q[0]  <= upbit_q[1];
        upbit_q[1]  <= upbit;
        prev_q      <= s1_q.val;
        out_valid_q <= s1_q.emit;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q       <= slot_i;
      byp_data_q <= line_wr;
    end
    if (s1_adv) begin
      out_q.pixel_out     <= result;
      out_q.last_of_frame <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/binary_isolated_background_fill.sv
// ----------------------------------------------------------------------------
// binary_isolated_background_fill
// Streaming filter that turns isolated background pixels of an edge map white.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and returns at most
// one result per clock. A pixel word goes through an input stage (line buffer
// read) and then the output register; in stream terms results lag the input
// by frame_width + 1 words, and frame_width + 1 flush words after the last
// pixel push out the final row. The line buffer is a single RAM with one
// write and one registered read per cycle. It is not cleared after reset:
// rows left from before reset or a register write lie outside the frame
// borders and never reach a result. Register writes restart the frame; the user
// must make them only while the stream is idle, the block does not enforce it.
module binary_isolated_background_fill (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bif_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bif_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bif_pkg::pix_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bif_pkg::pix_out_t             out_data_o
);
  import bif_pkg::*;

  logic      in_accept;
  logic      take;
  logic      busy;
  bif_slot_t slot;

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !busy;

  bif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_accept),
    .in_data_i  (in_data_i),
    .slot_o     (slot),
    .take_o     (take)
  );

  bif_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept && take),
    .slot_i     (slot),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // input back-pressure only comes from a full, stalled output
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // the frame-end word always yields a result
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && take && slot.last) |-> slot.emit)
    else $error("frame-end word without result");

  // the frame-end word is a flush word carrying the fill value into the line buffer
  a_last_is_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && take && slot.last) |-> (slot.val == PIX_FILL))
    else $error("frame-end word is not a flush word");

endmodule
